>>> src/qru_pkg.sv
// Shared types, constants and tables of the quaternion rotation unit.
// Depends on nothing; every other file of the block imports it.
package qru_pkg;

    localparam int WORD_W       = 32;
    localparam int FRAC_W       = 28;
    localparam int PROD_W       = 2 * WORD_W;
    localparam int ACC_W        = 40;
    localparam int NUM_LANES    = 4;
    localparam int NUM_TERMS    = 4;
    localparam int ANG_W        = 48;
    localparam int ANGLE_FRAC   = 40;
    localparam int CORDIC_ITERS = 24;
    localparam int COR_CNT_W    = $clog2(CORDIC_ITERS);
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = PROD_W;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_COMPOSE = 2'd1;
    localparam logic [1:0] MODE_ROTATE  = 2'd2;

    localparam logic signed [ANG_W-1:0] PI_ANGLE   = 48'sh3243F6A8886;
    localparam logic signed [ANG_W-1:0] HALF_PI    = PI_ANGLE >>> 1;
    localparam logic signed [ANG_W-1:0] TWO_PI     = PI_ANGLE <<< 1;
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 48'sd667681663043;

    typedef logic signed [ANG_W-1:0] t_ang_tab [CORDIC_ITERS];

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQUARE, ST_SUM, ST_SQRT, ST_CORDIC, ST_AXIS,
        ST_DIVGO, ST_DIV, ST_MAC, ST_INNER, ST_OUTER, ST_DONE
    } t_state;

    typedef enum logic [1:0] {COR_IDLE, COR_FOLD, COR_ITER, COR_OUT} t_cor_phase;

    typedef struct packed {
        logic accum;
        logic clr;
        logic neg;
    } t_lane_cmd;

    typedef struct packed {
        logic                     sat;
        logic signed [WORD_W-1:0] val;
    } t_clip;

    // Term tables: for each lane, which operands enter each of its four terms
    // and whether the term is subtracted (bit j of the mask is term j).
    localparam logic [1:0] CMP_QI [NUM_LANES][NUM_TERMS] =
        '{'{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2},
          '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd1, 2'd0}};
    localparam logic [3:0] CMP_NEG [NUM_LANES] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    localparam logic [1:0] IN_PT [NUM_LANES][NUM_TERMS] =
        '{'{2'd2, 2'd1, 2'd0, 2'd0}, '{2'd1, 2'd2, 2'd0, 2'd0},
          '{2'd0, 2'd2, 2'd1, 2'd0}, '{2'd0, 2'd1, 2'd2, 2'd0}};
    localparam logic [1:0] IN_QI [NUM_LANES][NUM_TERMS] =
        '{'{2'd0, 2'd1, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd3, 2'd0},
          '{2'd0, 2'd2, 2'd3, 2'd0}, '{2'd1, 2'd2, 2'd3, 2'd0}};
    localparam logic [3:0] IN_NEG [NUM_LANES] = '{4'b0100, 4'b0010, 4'b0100, 4'b0111};

    localparam logic [1:0] OUT_QI [NUM_LANES][NUM_TERMS] =
        '{'{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd1, 2'd0, 2'd3, 2'd2},
          '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd0, 2'd0, 2'd0}};
    localparam logic [3:0] OUT_NEG [NUM_LANES] = '{4'b1010, 4'b1001, 4'b1100, 4'b0000};

    // floor(2^e / d) by shift and subtract, for elaboration only.
    function automatic logic [ANG_W-1:0] f_pow_div(input int e, input int d);
        logic [ANG_W-1:0] q;
        logic [ANG_W-1:0] rem;
        int b;
        q   = '0;
        rem = '0;
        for (b = ANG_W - 1; b >= 0; b--) begin
            rem = {rem[ANG_W-2:0], (b == e)};
            if (rem >= ANG_W'(d)) begin
                rem  = rem - ANG_W'(d);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Step angles atan(2^-i) as the truncated arctangent series.
    function automatic t_ang_tab f_atan_tab();
        t_ang_tab tab;
        logic signed [ANG_W-1:0] sum;
        logic signed [ANG_W-1:0] term;
        int i;
        int k;
        tab[0] = PI_ANGLE >>> 2;
        for (i = 1; i < CORDIC_ITERS; i++) begin
            sum = '0;
            for (k = 0; i * (2 * k + 1) <= ANGLE_FRAC; k++) begin
                term = f_pow_div(ANGLE_FRAC - i * (2 * k + 1), 2 * k + 1);
                sum  = (k % 2 == 1) ? sum - term : sum + term;
            end
            tab[i] = sum;
        end
        return tab;
    endfunction

    localparam t_ang_tab ATAN_TAB = f_atan_tab();

    function automatic t_clip f_clip(input logic signed [ACC_W-1:0] v);
        t_clip c;
        c.sat = 1'b0;
        c.val = v[WORD_W-1:0];
        if (v > ACC_W'(signed'({1'b0, {(WORD_W-1){1'b1}}}))) begin
            c.sat = 1'b1;
            c.val = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (v < -ACC_W'(signed'({1'b0, 1'b1, {(WORD_W-1){1'b0}}}))) begin
            c.sat = 1'b1;
            c.val = {1'b1, {(WORD_W-1){1'b0}}};
        end
        return c;
    endfunction

endpackage

>>> src/qru_lane.sv
// One multiply-accumulate lane: a registered 32x32 product, then a rounded
// accumulate. Depends on qru_pkg.
module qru_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  qru_pkg::t_lane_cmd               i_cmd,
    input  logic signed [qru_pkg::WORD_W-1:0] i_x,
    input  logic signed [qru_pkg::WORD_W-1:0] i_y,
    output logic signed [qru_pkg::PROD_W-1:0] o_prod,
    output logic signed [qru_pkg::ACC_W-1:0]  o_acc
);
    import qru_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] rounded;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    t_lane_cmd                r_cmd;

    always_comb begin
        rounded = (r_prod + ROUND_HALF) >>> FRAC_W;
        n_acc   = r_cmd.clr ? '0 : r_acc;
        if (r_cmd.neg) begin
            n_acc = n_acc - rounded[ACC_W-1:0];
        end else begin
            n_acc = n_acc + rounded[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= '0;
        end else begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_x * i_y;
        if (r_cmd.accum) begin
            r_acc <= n_acc;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;
endmodule

>>> src/qru_sqrt.sv
// Integer square root, two radicand bits per cycle.
// Depends on qru_pkg.
module qru_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [qru_pkg::PROD_W-1:0]   i_n,
    output logic                         o_done,
    output logic [qru_pkg::WORD_W-1:0]   o_root
);
    import qru_pkg::*;

    localparam int CNT_W = $clog2(SQRT_STEPS);

    logic [PROD_W-1:0]   r_n;
    logic [WORD_W+1:0]   r_rem;
    logic [WORD_W-1:0]   r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [WORD_W+2:0]   rem_sh;
    logic [WORD_W+2:0]   trial;
    logic                fits;

    always_comb begin
        rem_sh = {r_rem[WORD_W:0], r_n[PROD_W-1:PROD_W-2]};
        trial  = {1'b0, r_root, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[PROD_W-3:0], 2'b00};
            r_rem  <= fits ? (WORD_W+2)'(rem_sh - trial) : rem_sh[WORD_W+1:0];
            r_root <= {r_root[WORD_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

>>> src/qru_cordic.sv
// Half-angle sine and cosine: angle reduction and folding, then a rotating
// CORDIC over the step-angle table. Depends on qru_pkg.
module qru_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [qru_pkg::WORD_W-1:0]        i_len,
    output logic                              o_done,
    output logic signed [qru_pkg::WORD_W-1:0] o_cos,
    output logic signed [qru_pkg::WORD_W-1:0] o_sin
);
    import qru_pkg::*;

    localparam int HALF_SHIFT = ANGLE_FRAC - FRAC_W - 1;
    localparam int OUT_SHIFT  = ANGLE_FRAC - FRAC_W;
    localparam logic signed [ANG_W-1:0] OUT_HALF = ANG_W'(1) <<< (OUT_SHIFT - 1);

    t_cor_phase              r_phase;
    t_cor_phase              n_phase;
    logic signed [ANG_W-1:0] r_t;
    logic signed [ANG_W-1:0] r_x;
    logic signed [ANG_W-1:0] r_y;
    logic                    r_neg;
    logic [COR_CNT_W-1:0]    r_cnt;
    logic                    r_done;
    logic signed [WORD_W-1:0] r_cos;
    logic signed [WORD_W-1:0] r_sin;
    logic signed [ANG_W-1:0] t_full;
    logic signed [ANG_W-1:0] t_red;
    logic signed [ANG_W-1:0] t_wrap;
    logic signed [ANG_W-1:0] t_fold;
    logic                    fold_neg;
    logic signed [ANG_W-1:0] x_sh;
    logic signed [ANG_W-1:0] y_sh;
    logic signed [ANG_W-1:0] x_fin;
    logic signed [ANG_W-1:0] cos_r;
    logic signed [ANG_W-1:0] sin_r;

    always_comb begin
        t_full   = signed'(ANG_W'(i_len) << HALF_SHIFT);
        t_red    = (t_full >= TWO_PI) ? t_full - TWO_PI : t_full;
        t_wrap   = (r_t > PI_ANGLE) ? r_t - TWO_PI : r_t;
        t_fold   = t_wrap;
        fold_neg = 1'b0;
        if (t_wrap > HALF_PI) begin
            t_fold   = PI_ANGLE - t_wrap;
            fold_neg = 1'b1;
        end else if (t_wrap < -HALF_PI) begin
            t_fold   = -PI_ANGLE - t_wrap;
            fold_neg = 1'b1;
        end
        x_sh  = r_x >>> r_cnt;
        y_sh  = r_y >>> r_cnt;
        x_fin = r_neg ? -r_x : r_x;
        cos_r = (x_fin + OUT_HALF) >>> OUT_SHIFT;
        sin_r = (r_y + OUT_HALF) >>> OUT_SHIFT;
    end

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            COR_IDLE: if (i_start) n_phase = COR_FOLD;
            COR_FOLD: n_phase = COR_ITER;
            COR_ITER: if (r_cnt == COR_CNT_W'(CORDIC_ITERS - 1)) n_phase = COR_OUT;
            COR_OUT:  n_phase = COR_IDLE;
            default:  n_phase = COR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= COR_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == COR_OUT);
            if (r_phase == COR_ITER) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            COR_IDLE: begin
                r_t <= t_red;
            end
            COR_FOLD: begin
                r_t   <= t_fold;
                r_neg <= fold_neg;
                r_x   <= CORDIC_GAIN;
                r_y   <= '0;
            end
            COR_ITER: begin
                if (!r_t[ANG_W-1]) begin
                    r_x <= r_x - y_sh;
                    r_y <= r_y + x_sh;
                    r_t <= r_t - ATAN_TAB[r_cnt];
                end else begin
                    r_x <= r_x + y_sh;
                    r_y <= r_y - x_sh;
                    r_t <= r_t + ATAN_TAB[r_cnt];
                end
            end
            COR_OUT: begin
                r_cos <= cos_r[WORD_W-1:0];
                r_sin <= sin_r[WORD_W-1:0];
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
endmodule

>>> src/qru_div.sv
// Signed-by-unsigned division truncating toward zero, one quotient bit per
// cycle. Depends on qru_pkg.
module qru_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [qru_pkg::PROD_W-1:0] i_dividend,
    input  logic [qru_pkg::WORD_W-1:0]        i_divisor,
    output logic                              o_done,
    output logic signed [qru_pkg::WORD_W-1:0] o_quot
);
    import qru_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [PROD_W-1:0] r_mag;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_divisor;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [WORD_W:0]   rem_sh;
    logic              fits;

    always_comb begin
        rem_sh = {r_rem, r_mag[PROD_W-1]};
        fits   = (rem_sh >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag     <= i_dividend[PROD_W-1] ? PROD_W'(-i_dividend) : PROD_W'(i_dividend);
            r_neg     <= i_dividend[PROD_W-1];
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_mag <= {r_mag[PROD_W-2:0], fits};
            r_rem <= fits ? WORD_W'(rem_sh - {1'b0, r_divisor}) : rem_sh[WORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -signed'(r_mag[WORD_W-1:0]) : signed'(r_mag[WORD_W-1:0]);
endmodule

>>> src/quaternion_rotation_unit.sv
// Top level of the quaternion rotation unit: sequencer, four MAC lanes,
// square root, CORDIC and dividers. Depends on qru_pkg and the qru_* modules.
//
// The unit holds an orientation quaternion (reset to identity) and takes one
// beat at a time. A load beat (mode 0) replaces the quaternion and returns it
// through the done state; the unused mode 3 returns the stored quaternion by
// the same path. A rotate beat (mode 2) forms four inner sums and then three
// outer sums on the four lanes and returns the point. A compose beat (mode 1)
// takes the longest, mostly in its serial root and divider: the squared
// length, the root, reduction and CORDIC, a division of the three axis terms
// running side by side, and the four-term quaternion product; a zero-length
// vector stops after the root and returns the stored quaternion unchanged.
// Every value is clipped to 32 bits and o_saturated reports any clip. The
// input side is stalled from acceptance until the result sits in the output
// register; a waiting result does not keep the next beat out.
module quaternion_rotation_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_mode,
    input  logic signed [qru_pkg::WORD_W-1:0] i_operand_a,
    input  logic signed [qru_pkg::WORD_W-1:0] i_operand_b,
    input  logic signed [qru_pkg::WORD_W-1:0] i_operand_c,
    input  logic signed [qru_pkg::WORD_W-1:0] i_operand_d,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [qru_pkg::WORD_W-1:0] o_result_a,
    output logic signed [qru_pkg::WORD_W-1:0] o_result_b,
    output logic signed [qru_pkg::WORD_W-1:0] o_result_c,
    output logic signed [qru_pkg::WORD_W-1:0] o_result_d,
    output logic                              o_saturated
);
    import qru_pkg::*;

    localparam logic signed [WORD_W-1:0] ONE_Q = WORD_W'(1) <<< FRAC_W;

    t_state                   r_state;
    t_state                   n_state;
    logic signed [WORD_W-1:0] r_q     [NUM_LANES];
    logic signed [WORD_W-1:0] r_op    [NUM_LANES];
    logic signed [WORD_W-1:0] r_inner [NUM_LANES];
    logic signed [WORD_W-1:0] r_res   [NUM_LANES];
    logic                     r_flag;
    logic [2:0]               r_cnt;
    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out   [NUM_LANES];
    logic                     r_out_sat;

    t_lane_cmd                lane_cmd  [NUM_LANES];
    logic signed [WORD_W-1:0] lane_x    [NUM_LANES];
    logic signed [WORD_W-1:0] lane_y    [NUM_LANES];
    logic signed [PROD_W-1:0] lane_prod [NUM_LANES];
    logic signed [ACC_W-1:0]  lane_acc  [NUM_LANES];
    t_clip                    lane_clip [NUM_LANES];
    logic signed [WORD_W-1:0] first_fac [NUM_TERMS];

    logic                     in_take;
    logic                     out_free;
    logic                     mac_issue;
    logic                     mac_last;
    logic [1:0]               term;
    logic                     sqrt_start;
    logic                     sqrt_done;
    logic [WORD_W-1:0]        root;
    logic                     cor_start;
    logic                     cor_done;
    logic signed [WORD_W-1:0] cos_h;
    logic signed [WORD_W-1:0] sin_h;
    logic                     div_start;
    logic [2:0]               div_done;
    logic signed [WORD_W-1:0] axis [3];
    logic [PROD_W-1:0]        norm_sq;

    // The input side is open only between items; the output register takes a
    // finished result as soon as it is empty or being emptied.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_take    = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign mac_issue  = !r_cnt[2];
    assign mac_last   = (r_cnt == 3'd5);
    assign term       = r_cnt[1:0];

    assign sqrt_start = (r_state == ST_SUM);
    assign cor_start  = (r_state == ST_SQRT) && sqrt_done && (root != '0);
    assign div_start  = (r_state == ST_DIVGO);
    assign norm_sq    = PROD_W'(lane_prod[0]) + PROD_W'(lane_prod[1]) + PROD_W'(lane_prod[2]);

    assign first_fac[0] = cos_h;
    assign first_fac[1] = axis[0];
    assign first_fac[2] = axis[1];
    assign first_fac[3] = axis[2];

    // Operand steering for the lanes. Squares and axis products use the raw
    // product only; the three sum phases accumulate four rounded terms each.
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            lane_cmd[k] = '0;
            lane_x[k]   = r_op[k];
            lane_y[k]   = r_op[k];
            case (r_state)
                ST_AXIS: begin
                    lane_x[k] = sin_h;
                end
                ST_MAC: begin
                    lane_cmd[k] = '{accum: mac_issue, clr: (term == 2'd0),
                                    neg: CMP_NEG[k][term]};
                    lane_x[k]   = first_fac[term];
                    lane_y[k]   = r_q[CMP_QI[k][term]];
                end
                ST_INNER: begin
                    lane_cmd[k] = '{accum: mac_issue, clr: (term == 2'd0),
                                    neg: IN_NEG[k][term]};
                    lane_x[k]   = (term == 2'd3) ? '0 : r_op[IN_PT[k][term]];
                    lane_y[k]   = r_q[IN_QI[k][term]];
                end
                ST_OUTER: begin
                    lane_cmd[k] = '{accum: mac_issue, clr: (term == 2'd0),
                                    neg: OUT_NEG[k][term]};
                    lane_x[k]   = (k == NUM_LANES - 1) ? '0 : r_q[OUT_QI[k][term]];
                    lane_y[k]   = r_inner[term];
                end
                default: begin
                    lane_cmd[k] = '0;
                end
            endcase
            lane_clip[k] = f_clip(lane_acc[k]);
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        qru_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (lane_cmd[g]),
            .i_x     (lane_x[g]),
            .i_y     (lane_y[g]),
            .o_prod  (lane_prod[g]),
            .o_acc   (lane_acc[g])
        );
    end

    qru_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_n     (norm_sq),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    qru_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_len   (root),
        .o_done  (cor_done),
        .o_cos   (cos_h),
        .o_sin   (sin_h)
    );

    // The three axis components divide side by side by the vector length.
    for (genvar g = 0; g < 3; g++) begin : g_div
        qru_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (lane_prod[g]),
            .i_divisor  (root),
            .o_done     (div_done[g]),
            .o_quot     (axis[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    case (i_mode)
                        MODE_COMPOSE: n_state = ST_SQUARE;
                        MODE_ROTATE:  n_state = ST_INNER;
                        default:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_SQUARE: n_state = ST_SUM;
            ST_SUM:    n_state = ST_SQRT;
            ST_SQRT: begin
                if (sqrt_done) begin
                    n_state = (root == '0) ? ST_DONE : ST_CORDIC;
                end
            end
            ST_CORDIC: if (cor_done) n_state = ST_AXIS;
            ST_AXIS:   n_state = ST_DIVGO;
            ST_DIVGO:  n_state = ST_DIV;
            ST_DIV:    if (div_done[0]) n_state = ST_MAC;
            ST_MAC:    if (mac_last) n_state = ST_DONE;
            ST_INNER:  if (mac_last) n_state = ST_OUTER;
            ST_OUTER:  if (mac_last) n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
            r_q[0]      <= ONE_Q;
            r_q[1]      <= '0;
            r_q[2]      <= '0;
            r_q[3]      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else if (!mac_last) begin
                r_cnt <= r_cnt + 1'b1;
            end

            // A finished result refills the output register in the same
            // cycle that the previous beat leaves it.
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_flag <= 1'b0;
                        if (i_mode == MODE_LOAD) begin
                            r_q[0] <= i_operand_a;
                            r_q[1] <= i_operand_b;
                            r_q[2] <= i_operand_c;
                            r_q[3] <= i_operand_d;
                        end
                    end
                end
                ST_MAC: begin
                    if (mac_last) begin
                        for (int k = 0; k < NUM_LANES; k++) begin
                            r_q[k] <= lane_clip[k].val;
                        end
                        r_flag <= lane_clip[0].sat | lane_clip[1].sat
                                | lane_clip[2].sat | lane_clip[3].sat;
                    end
                end
                ST_INNER: begin
                    if (mac_last) begin
                        r_flag <= lane_clip[0].sat | lane_clip[1].sat
                                | lane_clip[2].sat | lane_clip[3].sat;
                    end
                end
                ST_OUTER: begin
                    if (mac_last) begin
                        r_flag <= r_flag | lane_clip[0].sat | lane_clip[1].sat
                                | lane_clip[2].sat;
                    end
                end
                default: begin
                    r_flag <= r_flag;
                end
            endcase
        end
    end

    // Payload registers: operands, inner sums, the pending result and the
    // output register.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op[0] <= i_operand_a;
            r_op[1] <= i_operand_b;
            r_op[2] <= i_operand_c;
            r_op[3] <= i_operand_d;
        end
        if (r_state == ST_INNER && mac_last) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_inner[k] <= lane_clip[k].val;
            end
        end
        if (r_state == ST_OUTER && mac_last) begin
            for (int k = 0; k < NUM_LANES - 1; k++) begin
                r_res[k] <= lane_clip[k].val;
            end
            r_res[NUM_LANES-1] <= '0;
        end else if (r_state == ST_MAC && mac_last) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_res[k] <= lane_clip[k].val;
            end
        end else if (in_take) begin
            if (i_mode == MODE_LOAD) begin
                r_res[0] <= i_operand_a;
                r_res[1] <= i_operand_b;
                r_res[2] <= i_operand_c;
                r_res[3] <= i_operand_d;
            end else begin
                r_res <= r_q;
            end
        end
        if (r_state == ST_DONE && out_free) begin
            r_out     <= r_res;
            r_out_sat <= r_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result_a  = r_out[0];
    assign o_result_b  = r_out[1];
    assign o_result_c  = r_out[2];
    assign o_result_d  = r_out[3];
    assign o_saturated = r_out_sat;
endmodule
